>>> sv/crc_packet_deframer_macros.svh
// ----------------------------------------------------------------------------
// CRC packet deframer assertion macros
// Shared concurrent assertion forms used by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef CRC_PACKET_DEFRAMER_MACROS_SVH
`define CRC_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define CPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define CPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cpd_pkg.sv
// ----------------------------------------------------------------------------
// CRC packet deframer package
// Phase and role codes, the result record and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam logic [7:0]  MARKER_RESET   = 8'h55;
    localparam logic [15:0] CRC_SEED_RESET = 16'h1D0F;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd7;

    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_CRC_SEED     = 1'b1;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_CODE0   = 7'b0000010,
        PH_CODE1   = 7'b0000100,
        PH_LEN     = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CRC_HI  = 7'b0100000,
        PH_CRC_LO  = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_CODE0   = 3'd0,
        ROLE_CODE1   = 3'd1,
        ROLE_LEN     = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_STATUS  = 3'd4
    } role_t;

    typedef struct packed {
        logic [7:0] out_byte;
        role_t      byte_role;
        logic       crc_ok;
        logic [8:0] frame_length;
    } result_t;

    // CRC-16, MSB first, one byte folded in over eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

>>> sv/cpd_parser.sv
// ----------------------------------------------------------------------------
// CRC packet deframer parser
// Frame state machine and running CRC; forms one result per body byte and one status result per frame.
// ----------------------------------------------------------------------------
`include "crc_packet_deframer_macros.svh"

module cpd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        start_marker,
    input  logic [15:0]       crc_seed,
    input  logic              item_valid,
    input  logic [7:0]        item_byte,
    input  logic              res_ready,
    output logic              item_take,
    output logic              res_push,
    output cpd_pkg::result_t  res
);
    import cpd_pkg::*;

    phase_t      phase_reg,       phase_next;
    logic        prev_marker_reg, prev_marker_next;
    logic [15:0] crc_reg,         crc_next;
    logic [7:0]  bytes_left_reg,  bytes_left_next;
    logic [7:0]  payload_len_reg, payload_len_next;
    logic [7:0]  crc_hi_reg,      crc_hi_next;
    logic        res_valid;
    logic [15:0] crc_step;

    assign crc_step = crc_byte(crc_reg, item_byte);

    always_comb
    begin
        phase_next       = phase_reg;
        prev_marker_next = prev_marker_reg;
        crc_next         = crc_reg;
        bytes_left_next  = bytes_left_reg;
        payload_len_next = payload_len_reg;
        crc_hi_next      = crc_hi_reg;
        res_valid        = 1'b0;
        res              = '0;
        res.out_byte     = item_byte;
        unique case (phase_reg)
            PH_CODE0:
            begin
                crc_next      = crc_step;
                phase_next    = PH_CODE1;
                res_valid     = 1'b1;
                res.byte_role = ROLE_CODE0;
            end
            PH_CODE1:
            begin
                crc_next      = crc_step;
                phase_next    = PH_LEN;
                res_valid     = 1'b1;
                res.byte_role = ROLE_CODE1;
            end
            PH_LEN:
            begin
                crc_next         = crc_step;
                payload_len_next = item_byte;
                bytes_left_next  = item_byte;
                phase_next       = (item_byte != 8'd0) ? PH_PAYLOAD : PH_CRC_HI;
                res_valid        = 1'b1;
                res.byte_role    = ROLE_LEN;
            end
            PH_PAYLOAD:
            begin
                crc_next        = crc_step;
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1)
                    phase_next = PH_CRC_HI;
                res_valid     = 1'b1;
                res.byte_role = ROLE_PAYLOAD;
            end
            PH_CRC_HI:
            begin
                crc_hi_next = item_byte;
                phase_next  = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                res_valid        = 1'b1;
                res.out_byte     = 8'd0;
                res.byte_role    = ROLE_STATUS;
                res.crc_ok       = ({crc_hi_reg, item_byte} == crc_reg);
                res.frame_length = {1'b0, payload_len_reg} + FRAME_OVERHEAD;
                phase_next       = PH_HUNT;
                prev_marker_next = 1'b0;
            end
            default:
            begin
                // Hunting; also recovers from any code outside the phase set.
                phase_next = PH_HUNT;
                if (item_byte == start_marker)
                begin
                    if (prev_marker_reg)
                    begin
                        prev_marker_next = 1'b0;
                        crc_next         = crc_seed;
                        phase_next       = PH_CODE0;
                    end
                    else
                    begin
                        prev_marker_next = 1'b1;
                    end
                end
                else
                begin
                    prev_marker_next = 1'b0;
                end
            end
        endcase
    end

    // An item that yields nothing never waits for output space.
    assign item_take = item_valid && (!res_valid || res_ready);
    assign res_push  = item_take && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            prev_marker_reg <= 1'b0;
            crc_reg         <= CRC_SEED_RESET;
            bytes_left_reg  <= 8'd0;
            payload_len_reg <= 8'd0;
            crc_hi_reg      <= 8'd0;
        end
        else if (item_take)
        begin
            phase_reg       <= phase_next;
            prev_marker_reg <= prev_marker_next;
            crc_reg         <= crc_next;
            bytes_left_reg  <= bytes_left_next;
            payload_len_reg <= payload_len_next;
            crc_hi_reg      <= crc_hi_next;
        end
    end

    `CPD_ASSERT_NXT(a_payload_end, item_take && phase_reg == PH_PAYLOAD && bytes_left_reg == 8'd1, phase_reg == PH_CRC_HI, "last payload byte did not lead to the CRC bytes")
    `CPD_ASSERT_NXT(a_status_rehunt, item_take && phase_reg == PH_CRC_LO, phase_reg == PH_HUNT && !prev_marker_reg, "hunting did not resume after a frame")
    `CPD_ASSERT_IMP(a_payload_count, phase_reg == PH_PAYLOAD, bytes_left_reg != 8'd0 && bytes_left_reg <= payload_len_reg, "payload count out of range")

endmodule

>>> sv/cpd_out_reg.sv
// ----------------------------------------------------------------------------
// CRC packet deframer output register
// Holds one result for the master side until the receiver takes it.
// ----------------------------------------------------------------------------
`include "crc_packet_deframer_macros.svh"

module cpd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  cpd_pkg::result_t  res,
    output logic              res_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cpd_pkg::result_t  out_res
);
    import cpd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign res_ready  = !valid_reg || out_ready;
    assign valid_next = res_push || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            data_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    `CPD_ASSERT_IMP(a_no_overwrite, res_push, res_ready, "result pushed into a full output register")
    `CPD_ASSERT_NXT(a_push_shows, res_push, valid_reg, "pushed result not presented")
    `CPD_ASSERT_IMP(a_status_fields, valid_reg && data_reg.byte_role != ROLE_STATUS, !data_reg.crc_ok && data_reg.frame_length == 9'd0, "status fields set on a body byte")

endmodule

>>> sv/crc_packet_deframer.sv
// ----------------------------------------------------------------------------
// CRC packet deframer
// Finds marker-opened frames in a byte stream and checks their CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one received byte per item. The master stream
//   carries one result per frame body byte (code, code, length, payloads),
//   tagged by role in tuser, and one status item after the last CRC byte
//   with crc_ok and the total frame length. Marker and CRC bytes and bytes
//   outside a frame give no item.
//   An accepted byte is held in the input register, then its result is
//   written to the output register. A byte is processed in every cycle,
//   so throughput is one item per cycle unless a result waits on a
//   stalled receiver; the CRC byte update is the longest path in between.
//   When the receiver stalls, the output register holds its result and the
//   input register takes one more byte; further bytes are held off by
//   s_tready. Bytes that give no result keep flowing during a stall.
//   Reset empties both registers, starts hunting, and loads the marker
//   0x55 and the CRC seed 0x1D0F. Configuration is written through cfg_we,
//   cfg_index and cfg_data while the stream is idle.
// ----------------------------------------------------------------------------
module crc_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [8] crc_ok, [17:9] frame_length
    output logic [2:0]  m_tuser    // [2:0] byte_role
);
    import cpd_pkg::*;

    logic [7:0]  start_marker_reg;
    logic [15:0] crc_seed_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        item_take;
    logic        res_push;
    logic        res_ready;
    result_t     res;
    result_t     out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= MARKER_RESET;
            crc_seed_reg     <= CRC_SEED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_data[7:0];
                CFG_CRC_SEED:     crc_seed_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign s_tready = !in_valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    cpd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_marker (start_marker_reg),
        .crc_seed     (crc_seed_reg),
        .item_valid   (in_valid_reg),
        .item_byte    (in_byte_reg),
        .res_ready    (res_ready),
        .item_take    (item_take),
        .res_push     (res_push),
        .res          (res)
    );

    cpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'd0, out_res.frame_length, out_res.crc_ok, out_res.out_byte};
    assign m_tuser = out_res.byte_role;

endmodule
